// ===== rtl/core/uncore_event_counter_bank_unit_assert.svh =====
// assertion macros shared by the event counter bank modules
// each macro expects signals named clock and reset in the using module
`ifndef UNCORE_EVENT_COUNTER_BANK_UNIT_ASSERT_SVH
`define UNCORE_EVENT_COUNTER_BANK_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UECB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UECB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/uecb_pkg.sv =====
// shared constants, types and register map of the event counter bank
// no dependencies
`default_nettype none

package uecb_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int NUM_COUNTERS = 4;
   localparam int COUNT_WIDTH  = 32;

   localparam int CMD_W   = 2;
   localparam int CH_W    = 4;
   localparam int OFF_W   = 12;
   localparam int DATA_W  = 32;
   localparam int EVT_W   = 5;
   localparam int CHCNT_W = 5;
   localparam int LIMIT_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ROW_DEPTH = 1 << CH_IDX_W;
   localparam int CTR_IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_LAYOUT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_LIMIT  = 2'd2;

   localparam logic               LAYOUT_RST   = 1'b0;
   localparam logic [CHCNT_W-1:0] CHANNELS_RST = 5'd16;
   localparam logic [LIMIT_W-1:0] LIMIT_RST    = 6'd24;

   localparam logic LAYOUT_PER_COUNTER = 1'b0;
   localparam logic LAYOUT_SHARED      = 1'b1;

   // register map
   localparam int CTL_PER_BASE     = 'hA8;
   localparam int DATA_PER_BASE    = 'hAC;
   localparam int PER_STRIDE       = 8;
   localparam int CTL_SHARED       = 'h234;
   localparam int DATA_SHARED_BASE = 'h240;
   localparam int SHARED_STRIDE    = 'hC;
   localparam int EVT_LSB_PER      = 3;
   localparam int EVT_LSB_SHARED   = 1;
   localparam int SHARED_FIELD_STRIDE = 8;

   typedef logic [NUM_COUNTERS-1:0][COUNT_WIDTH-1:0] cnt_row_type;
   typedef logic [NUM_COUNTERS-1:0][DATA_W-1:0]      ctl_row_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } uecb_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/uecb_channels.sv =====
// handshake channel interfaces for requests, responses and configuration
// depends on uecb_pkg
`default_nettype none

interface uecb_req_if;
   logic                          valid;
   logic                          ready;
   logic [uecb_pkg::CMD_W-1:0]    command;
   logic [uecb_pkg::CH_W-1:0]     channel;
   logic [uecb_pkg::OFF_W-1:0]    reg_offset;
   logic [uecb_pkg::DATA_W-1:0]   write_data;
   logic [uecb_pkg::DATA_W-1:0]   event_pulses;

   modport source (output valid, command, channel, reg_offset, write_data, event_pulses,
                   input ready);
   modport sink   (input valid, command, channel, reg_offset, write_data, event_pulses,
                   output ready);
endinterface

interface uecb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [uecb_pkg::DATA_W-1:0]   read_data;
   logic                          access_error;

   modport source (output valid, read_data, access_error, input ready);
   modport sink   (input valid, read_data, access_error, output ready);
endinterface

interface uecb_csr_if;
   logic                              valid;
   logic                              ready;
   logic [uecb_pkg::CSR_IDX_W-1:0]    index;
   logic [uecb_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/uecb_ctrl.sv =====
// sequencing of one word at a time: capture, execute, hold for response slot
// depends on uecb_pkg and the assertion macro header
`default_nettype none

module uecb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output uecb_pkg::uecb_cmd_type cmd
);
   import uecb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute = (state_ff == ST_EXEC) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (slot_free) begin
                  // result goes straight into the output register
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`include "uncore_event_counter_bank_unit_assert.svh"

   `UECB_ASSERT_NEXT(a_accept_to_exec, req_valid && req_ready, state_ff == ST_EXEC, "accepted word did not start execution")
   `UECB_ASSERT_NEXT(a_exec_gives_rsp, cmd.execute, rsp_valid_ff && state_ff == ST_IDLE, "execution did not load the response")
   `UECB_ASSERT_NOW(a_one_cmd, 1'b1, !(cmd.capture && cmd.execute), "capture and execute together")

endmodule

`default_nettype wire

// ===== rtl/core/uecb_datapath.sv =====
// counter and control word storage, offset decode, tick update and response register
// depends on uecb_pkg and the assertion macro header
`default_nettype none

module uecb_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  uecb_pkg::uecb_cmd_type         cmd,
   input  logic [uecb_pkg::CMD_W-1:0]     req_command,
   input  logic [uecb_pkg::CH_W-1:0]      req_channel,
   input  logic [uecb_pkg::OFF_W-1:0]     req_reg_offset,
   input  logic [uecb_pkg::DATA_W-1:0]    req_write_data,
   input  logic [uecb_pkg::DATA_W-1:0]    req_event_pulses,
   input  logic                           csr_write,
   input  logic [uecb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uecb_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [uecb_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                           rsp_access_error
);
   import uecb_pkg::*;

   localparam logic [CHCNT_W-1:0] CHAN_LIMIT = CHCNT_W'(NUM_CHANNELS);

   // configuration
   logic               layout_ff;
   logic [CHCNT_W-1:0] chans_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // captured word
   logic [CMD_W-1:0]  cmd_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [DATA_W-1:0] pulses_ff;

   // storage, one row per channel
   cnt_row_type cnt_mem [ROW_DEPTH];
   ctl_row_type ctl_mem [ROW_DEPTH];
   cnt_row_type rd_cnt_ff;
   ctl_row_type rd_ctl_ff;
   logic [ROW_DEPTH-1:0][NUM_COUNTERS-1:0] cnt_vld_ff;
   logic [ROW_DEPTH-1:0][NUM_COUNTERS-1:0] ctl_vld_ff;

   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_err_ff;

   logic [CH_IDX_W-1:0]     rd_idx;
   logic [CH_IDX_W-1:0]     row_idx;
   cnt_row_type             eff_cnt;
   ctl_row_type             eff_ctl;
   logic [NUM_COUNTERS-1:0][EVT_W-1:0] evt;
   logic                    ch_ok;
   logic                    dec_ctl;
   logic                    dec_data;
   logic [CTR_IDX_W-1:0]    dec_k;
   logic [CTR_IDX_W-1:0]    ctl_sel;
   logic [NUM_COUNTERS-1:0] cnt_we;
   logic [NUM_COUNTERS-1:0] ctl_we;
   cnt_row_type             cnt_wd;
   logic [DATA_W-1:0]       rdata;
   logic                    err;

   assign rd_idx  = req_channel[CH_IDX_W-1:0];
   assign row_idx = ch_ff[CH_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_RST;
         chans_ff  <= CHANNELS_RST;
         limit_ff  <= LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_UNIT_LAYOUT: layout_ff <= csr_data[0];
            CSR_CHANNELS:    chans_ff  <= csr_data[CHCNT_W-1:0];
            CSR_EVENT_LIMIT: limit_ff  <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         ch_ff     <= req_channel;
         off_ff    <= req_reg_offset;
         wdata_ff  <= req_write_data;
         pulses_ff <= req_event_pulses;
      end
   end

   // row memories: registered read on capture, lane-masked write on execute
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_cnt_ff <= cnt_mem[rd_idx];
         rd_ctl_ff <= ctl_mem[rd_idx];
      end
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         if (cmd.execute && cnt_we[k]) begin
            cnt_mem[row_idx][k] <= cnt_wd[k];
         end
         if (cmd.execute && ctl_we[k]) begin
            ctl_mem[row_idx][k] <= wdata_ff;
         end
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         ctl_vld_ff <= '0;
      end else if (cmd.execute) begin
         cnt_vld_ff[row_idx] <= cnt_vld_ff[row_idx] | cnt_we;
         ctl_vld_ff[row_idx] <= ctl_vld_ff[row_idx] | ctl_we;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         eff_cnt[k] = cnt_vld_ff[row_idx][k] ? rd_cnt_ff[k] : '0;
         eff_ctl[k] = ctl_vld_ff[row_idx][k] ? rd_ctl_ff[k] : '0;
      end
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         if (layout_ff == LAYOUT_PER_COUNTER) begin
            evt[k] = eff_ctl[k][EVT_LSB_PER +: EVT_W];
         end else begin
            evt[k] = eff_ctl[0][SHARED_FIELD_STRIDE*k + EVT_LSB_SHARED +: EVT_W];
         end
      end
   end

   // offset decode against the active layout
   always_comb begin
      dec_ctl  = 1'b0;
      dec_data = 1'b0;
      dec_k    = '0;
      if (layout_ff == LAYOUT_PER_COUNTER) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            if (off_ff == OFF_W'(CTL_PER_BASE + PER_STRIDE*k)) begin
               dec_ctl = 1'b1;
               dec_k   = CTR_IDX_W'(k);
            end
            if (off_ff == OFF_W'(DATA_PER_BASE + PER_STRIDE*k)) begin
               dec_data = 1'b1;
               dec_k    = CTR_IDX_W'(k);
            end
         end
      end else begin
         if (off_ff == OFF_W'(CTL_SHARED)) begin
            dec_ctl = 1'b1;
         end
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            if (off_ff == OFF_W'(DATA_SHARED_BASE + SHARED_STRIDE*k)) begin
               dec_data = 1'b1;
               dec_k    = CTR_IDX_W'(k);
            end
         end
      end
   end

   assign ch_ok   = ({1'b0, ch_ff} < chans_ff) && ({1'b0, ch_ff} < CHAN_LIMIT);
   assign ctl_sel = (layout_ff == LAYOUT_PER_COUNTER) ? dec_k : '0;

   always_comb begin
      cnt_we = '0;
      ctl_we = '0;
      cnt_wd = eff_cnt;
      rdata  = '0;
      err    = 1'b0;
      if (!ch_ok) begin
         err = 1'b1;
      end else begin
         case (cmd_ff)
            CMD_TICK: begin
               for (int k = 0; k < NUM_COUNTERS; k++) begin
                  if ((evt[k] != '0) && ({1'b0, evt[k]} < limit_ff) && pulses_ff[evt[k]]) begin
                     cnt_we[k] = 1'b1;
                     cnt_wd[k] = eff_cnt[k] + COUNT_WIDTH'(1);
                  end
               end
            end
            CMD_READ, CMD_WRITE: begin
               if (dec_ctl) begin
                  if (cmd_ff == CMD_READ) begin
                     rdata = eff_ctl[ctl_sel];
                  end else begin
                     ctl_we[ctl_sel] = 1'b1;
                  end
               end else if (dec_data) begin
                  if (cmd_ff == CMD_READ) begin
                     rdata = DATA_W'(eff_cnt[dec_k]);
                  end else begin
                     cnt_we[dec_k] = 1'b1;
                     cnt_wd[dec_k] = wdata_ff[COUNT_WIDTH-1:0];
                  end
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_data_ff <= rdata;
         rsp_err_ff  <= err;
      end
   end

   assign rsp_read_data    = rsp_data_ff;
   assign rsp_access_error = rsp_err_ff;

`include "uncore_event_counter_bank_unit_assert.svh"

   `UECB_ASSERT_NOW(a_err_no_write, cmd.execute && err,
      cnt_we == '0 && ctl_we == '0, "rejected word changed storage")
   `UECB_ASSERT_NOW(a_read_no_write, cmd.execute && cmd_ff == CMD_READ,
      cnt_we == '0 && ctl_we == '0, "read word changed storage")
   `UECB_ASSERT_NEXT(a_cnt_vld_set, cmd.execute && (cnt_we != '0),
      (cnt_vld_ff[$past(row_idx)] & $past(cnt_we)) == $past(cnt_we),
      "counter write left entry invalid")

endmodule

`default_nettype wire

// ===== rtl/core/uncore_event_counter_bank_unit.sv =====
// Event counter bank: NUM_COUNTERS counters per channel for NUM_CHANNELS channels.
// Channels: req_chan carries bus reads, bus writes and event ticks, one word each;
//    rsp_chan returns exactly one word (read_data, access_error) per request, in order;
//    csr_chan writes unit_layout (0), channels_in_use (1) and event_limit (2) and is
//    always ready; the user must write it only while no request is in flight; the bank
//    itself does not enforce this.
// Response: a captured request executes in the execute state, which loads the response
//    register once that register is free.
// Flow: each request reads its channel's counter row and control row from single-port
//    row memories on capture and writes back in the execute state; req_chan.ready is
//    high only in the idle state, so a new request waits until the last has executed.
// Stall: while a response waits, the bank still accepts one request and computes it, but
//    holds it (and req_chan.ready low) until rsp_chan.ready frees the response register.
// Reset: synchronous on reset; configuration returns to layout 0, 16 channels, limit 24;
//    per-entry valid bits clear so every counter and control word reads zero (no sweep).
// Depends on uecb_pkg, the channel interfaces, uecb_ctrl and uecb_datapath.
`default_nettype none

module uncore_event_counter_bank_unit (
   input  logic         clock,
   input  logic         reset,
   uecb_req_if.sink     req_chan,
   uecb_rsp_if.source   rsp_chan,
   uecb_csr_if.sink     csr_chan
);
   import uecb_pkg::*;

   uecb_cmd_type cmd;
   logic         ctrl_req_ready;
   logic         ctrl_rsp_valid;
   logic         csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;
   assign req_chan.ready = ctrl_req_ready;
   assign rsp_chan.valid = ctrl_rsp_valid;

   uecb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   uecb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_command      (req_chan.command),
      .req_channel      (req_chan.channel),
      .req_reg_offset   (req_chan.reg_offset),
      .req_write_data   (req_chan.write_data),
      .req_event_pulses (req_chan.event_pulses),
      .csr_write        (csr_write),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .rsp_read_data    (rsp_chan.read_data),
      .rsp_access_error (rsp_chan.access_error)
   );

endmodule

`default_nettype wire

// ===== test/tb_uncore_event_counter_bank_unit.sv =====
// self-checking testbench for uncore_event_counter_bank_unit: directed and random
// reads, writes and ticks against an in-bench model; needs uecb_pkg and the channel interfaces
module tb_uncore_event_counter_bank_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import uecb_pkg::*;

   localparam int BANK_DEPTH    = NUM_CHANNELS * NUM_COUNTERS;
   localparam int WORDS_PER_SEG = 240;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              access_error;
   } rsp_word_t;

   typedef enum int {REG_NONE, REG_CTL, REG_DATA} reg_kind_e;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   uecb_req_if req_bus ();
   uecb_rsp_if rsp_bus ();
   uecb_csr_if csr_bus ();

   uncore_event_counter_bank_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // model copy of the bank and its configuration
   logic [COUNT_WIDTH-1:0] count_mem [BANK_DEPTH];
   logic [DATA_W-1:0]      ctl_mem   [BANK_DEPTH];
   logic                   cfg_layout;
   logic [CHCNT_W-1:0]     cfg_channels;
   logic [LIMIT_W-1:0]     cfg_limit;

   rsp_word_t awaited_words [$];
   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // updates the model for one accepted word and returns the response it should give
   function automatic void predict_access(input logic [CMD_W-1:0] cmd,
                                          input logic [CH_W-1:0] ch,
                                          input logic [OFF_W-1:0] off,
                                          input logic [DATA_W-1:0] wdata,
                                          input logic [DATA_W-1:0] pulses,
                                          output rsp_word_t word);
      int unsigned d, k, base, idx, shift;
      logic [EVT_W-1:0] evt;
      reg_kind_e kind;
      word = '0;
      if (cmd == CMD_RSVD || ch >= cfg_channels || ch >= NUM_CHANNELS) begin
         word.access_error = 1'b1;
         return;
      end
      base = ch * NUM_COUNTERS;
      if (cmd == CMD_TICK) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            shift = SHARED_FIELD_STRIDE * i + EVT_LSB_SHARED;
            if (cfg_layout == LAYOUT_PER_COUNTER)
               evt = ctl_mem[base + i][EVT_LSB_PER +: EVT_W];
            else
               evt = ctl_mem[base][shift +: EVT_W];
            if (evt != 0 && evt < cfg_limit && pulses[evt])
               count_mem[base + i] = count_mem[base + i] + 1'b1;
         end
         return;
      end
      kind = REG_NONE;
      k = 0;
      if (cfg_layout == LAYOUT_PER_COUNTER) begin
         if (off >= CTL_PER_BASE) begin
            d = off - CTL_PER_BASE;
            k = d / PER_STRIDE;
            if (k < NUM_COUNTERS) begin
               if (d % PER_STRIDE == 0)
                  kind = REG_CTL;
               else if (d % PER_STRIDE == DATA_PER_BASE - CTL_PER_BASE)
                  kind = REG_DATA;
            end
         end
      end else if (off == CTL_SHARED) begin
         kind = REG_CTL;
      end else if (off >= DATA_SHARED_BASE) begin
         d = off - DATA_SHARED_BASE;
         k = d / SHARED_STRIDE;
         if (d % SHARED_STRIDE == 0 && k < NUM_COUNTERS)
            kind = REG_DATA;
      end
      case (kind)
         REG_NONE: word.access_error = 1'b1;
         REG_CTL: begin
            idx = (cfg_layout == LAYOUT_PER_COUNTER) ? base + k : base;
            if (cmd == CMD_READ)
               word.read_data = ctl_mem[idx];
            else
               ctl_mem[idx] = wdata;
         end
         default: begin
            idx = base + k;
            if (cmd == CMD_READ)
               word.read_data = count_mem[idx];
            else
               count_mem[idx] = wdata[COUNT_WIDTH-1:0];
         end
      endcase
   endfunction

   // offset of a control word or data register in the current layout
   function automatic logic [OFF_W-1:0] reg_addr(input bit is_ctl, input int k);
      if (cfg_layout == LAYOUT_PER_COUNTER)
         return OFF_W'(is_ctl ? CTL_PER_BASE + PER_STRIDE * k : DATA_PER_BASE + PER_STRIDE * k);
      return OFF_W'(is_ctl ? CTL_SHARED : DATA_SHARED_BASE + SHARED_STRIDE * k);
   endfunction

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                            input logic [OFF_W-1:0] off, input logic [DATA_W-1:0] wdata,
                            input logic [DATA_W-1:0] pulses);
      rsp_word_t word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.command      = cmd;
      req_bus.channel      = ch;
      req_bus.reg_offset   = off;
      req_bus.write_data   = wdata;
      req_bus.event_pulses = pulses;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_access(cmd, ch, off, wdata, pulses, word);
      awaited_words.push_back(word);
      @(negedge clock);
   endtask

   // sender holds off until every response is back
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (awaited_words.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      case (idx)
         CSR_UNIT_LAYOUT: cfg_layout   = data[0];
         CSR_CHANNELS:    cfg_channels = data[CHCNT_W-1:0];
         CSR_EVENT_LIMIT: cfg_limit    = data[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic random_item();
      logic [CMD_W-1:0]  cmd;
      logic [CH_W-1:0]   ch;
      logic [OFF_W-1:0]  off;
      logic [DATA_W-1:0] wdata, pulses;
      int r, top;
      r = $urandom_range(99);
      if (r < 40)
         cmd = CMD_TICK;
      else if (r < 70)
         cmd = CMD_WRITE;
      else if (r < 95)
         cmd = CMD_READ;
      else
         cmd = CMD_RSVD;
      top = (cfg_channels > NUM_CHANNELS) ? NUM_CHANNELS - 1 : cfg_channels - 1;
      if ($urandom_range(9) != 0 && cfg_channels != 0)
         ch = $urandom_range(top);
      else
         ch = $urandom;
      r = $urandom_range(99);
      if (r < 85)
         off = reg_addr($urandom_range(1), $urandom_range(NUM_COUNTERS - 1));
      else if (r < 93)
         // near misses: misaligned, and one counter past the end
         off = reg_addr($urandom_range(1), $urandom_range(NUM_COUNTERS)) + $urandom_range(3);
      else
         off = $urandom;
      wdata = $urandom;
      if ($urandom_range(3) == 0)
         wdata = 32'hFFFF_FFFF - $urandom_range(3);
      r = $urandom_range(15);
      if (r < 2)
         pulses = '1;
      else if (r == 2)
         pulses = '0;
      else
         pulses = $urandom;
      send_word(cmd, ch, off, wdata, pulses);
   endtask

   task automatic test_per_counter_layout();
      send_word(CMD_READ, 0, reg_addr(1, 0), $urandom, $urandom);
      send_word(CMD_READ, 15, reg_addr(0, 3), $urandom, $urandom);
      send_word(CMD_WRITE, 0, reg_addr(1, 0), 32'hFFFF_FF2F, $urandom);
      send_word(CMD_WRITE, 0, reg_addr(1, 1), 32'(23) << EVT_LSB_PER, $urandom);
      send_word(CMD_WRITE, 0, reg_addr(1, 2), 32'(24) << EVT_LSB_PER, $urandom);
      send_word(CMD_WRITE, 0, reg_addr(1, 3), 32'hFFFF_FF07, $urandom);
      send_word(CMD_WRITE, 0, reg_addr(0, 0), 32'hFFFF_FFFF, $urandom);
      // counter 0 wraps, id at the limit and id zero stay put
      send_word(CMD_TICK, 0, $urandom, $urandom, '1);
      for (int k = 0; k < NUM_COUNTERS; k++)
         send_word(CMD_READ, 0, reg_addr(0, k), $urandom, $urandom);
      send_word(CMD_READ, 0, reg_addr(1, 0), $urandom, $urandom);
      send_word(CMD_TICK, 0, $urandom, $urandom, '0);
      send_word(CMD_READ, 0, 12'h000, $urandom, $urandom);
      send_word(CMD_READ, 0, 12'h0A9, $urandom, $urandom);
      send_word(CMD_READ, 0, reg_addr(1, NUM_COUNTERS), $urandom, $urandom);
      send_word(CMD_READ, 0, reg_addr(0, NUM_COUNTERS), $urandom, $urandom);
      send_word(CMD_READ, 0, 12'hFFF, $urandom, $urandom);
      send_word(CMD_WRITE, 0, 12'h0AE, $urandom, $urandom);
      send_word(CMD_RSVD, 0, reg_addr(0, 0), $urandom, '1);
      send_word(CMD_TICK, 15, $urandom, $urandom, '1);
      send_word(CMD_READ, 0, reg_addr(0, 1), $urandom, $urandom);
   endtask

   task automatic test_shared_layout();
      logic [DATA_W-1:0] shared_ctl;
      shared_ctl = 32'h8000_0081 | (32'(1) << 1) | (32'(31) << 9) | (32'(23) << 17);
      csr_write(CSR_UNIT_LAYOUT, LAYOUT_SHARED);
      send_word(CMD_WRITE, 3, reg_addr(1, 0), shared_ctl, $urandom);
      send_word(CMD_READ, 3, reg_addr(1, 0), $urandom, $urandom);
      send_word(CMD_WRITE, 3, reg_addr(0, 3), 32'hFFFF_FFFE, $urandom);
      send_word(CMD_WRITE, 3, reg_addr(0, 0), 32'hFFFF_FFFF, $urandom);
      send_word(CMD_TICK, 3, $urandom, $urandom, '1);
      for (int k = 0; k < NUM_COUNTERS; k++)
         send_word(CMD_READ, 3, reg_addr(0, k), $urandom, $urandom);
      send_word(CMD_READ, 3, 12'h235, $urandom, $urandom);
      send_word(CMD_READ, 3, 12'h23C, $urandom, $urandom);
      send_word(CMD_READ, 3, 12'h244, $urandom, $urandom);
      send_word(CMD_READ, 3, reg_addr(0, NUM_COUNTERS), $urandom, $urandom);
      send_word(CMD_READ, 3, 12'h0A8, $urandom, $urandom);
      send_word(CMD_WRITE, 3, 12'h241, $urandom, $urandom);
      // id 31 only counts once the limit is raised to 32
      csr_write(CSR_EVENT_LIMIT, 32);
      send_word(CMD_TICK, 3, $urandom, $urandom, 32'h8000_0000);
      send_word(CMD_READ, 3, reg_addr(0, 1), $urandom, $urandom);
      // shared word stays visible as counter 0's control word
      csr_write(CSR_UNIT_LAYOUT, LAYOUT_PER_COUNTER);
      send_word(CMD_READ, 3, reg_addr(1, 0), $urandom, $urandom);
      send_word(CMD_READ, 3, reg_addr(1, 1), $urandom, $urandom);
   endtask

   task automatic test_channel_and_limit_edges();
      csr_write(CSR_CHANNELS, 0);
      send_word(CMD_READ, 0, reg_addr(0, 0), $urandom, $urandom);
      send_word(CMD_TICK, 0, $urandom, $urandom, '1);
      csr_write(CSR_CHANNELS, 1);
      send_word(CMD_TICK, 0, $urandom, $urandom, '1);
      send_word(CMD_READ, 1, reg_addr(0, 0), $urandom, $urandom);
      csr_write(CSR_CHANNELS, 31);
      send_word(CMD_READ, 15, reg_addr(0, 0), $urandom, $urandom);
      csr_write(CSR_EVENT_LIMIT, 0);
      send_word(CMD_TICK, 0, $urandom, $urandom, '1);
      csr_write(CSR_EVENT_LIMIT, 63);
      send_word(CMD_TICK, 0, $urandom, $urandom, '1);
      send_word(CMD_READ, 0, reg_addr(0, 1), $urandom, $urandom);
      csr_write(CSR_CHANNELS, 16);
      csr_write(CSR_EVENT_LIMIT, 24);
   endtask

   task automatic test_random_traffic();
      int layout_tab [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
      int chan_tab   [8] = '{16, 16, 1, 7, 16, 1, 11, 16};
      int limit_tab  [8] = '{24, 32, 1, 17, 32, 1, 6, 24};
      int pause_at;
      for (int seg = 0; seg < 8; seg++) begin
         csr_write(CSR_UNIT_LAYOUT, layout_tab[seg]);
         csr_write(CSR_CHANNELS, chan_tab[seg]);
         csr_write(CSR_EVENT_LIMIT, limit_tab[seg]);
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         pause_at = $urandom_range(WORDS_PER_SEG - 1);
         for (int i = 0; i < WORDS_PER_SEG; i++) begin
            if (i == pause_at)
               drain_results();
            random_item();
         end
      end
   endtask

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : check_rsp
      rsp_word_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: unexpected response, expected none, got read_data %h error %b",
                     $time, rsp_bus.read_data, rsp_bus.access_error);
            error_count++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_bus.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h got %h",
                        $time, want.read_data, rsp_bus.read_data);
               error_count++;
            end
            if (rsp_bus.access_error !== want.access_error) begin
               $display("%0t: access_error expected %b got %b",
                        $time, want.access_error, rsp_bus.access_error);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_READ;
      req_bus.channel      = '0;
      req_bus.reg_offset   = '0;
      req_bus.write_data   = '0;
      req_bus.event_pulses = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_UNIT_LAYOUT;
      csr_bus.data         = '0;
      for (int i = 0; i < BANK_DEPTH; i++) begin
         count_mem[i] = '0;
         ctl_mem[i]   = '0;
      end
      cfg_layout   = LAYOUT_RST;
      cfg_channels = CHANNELS_RST;
      cfg_limit    = LIMIT_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_per_counter_layout();
      test_shared_layout();
      test_channel_and_limit_edges();
      test_random_traffic();

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("uncore_event_counter_bank_unit: match");
      else
         $display("uncore_event_counter_bank_unit: mismatch");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("uncore_event_counter_bank_unit: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/uecb_pkg.sv
rtl/core/uecb_channels.sv
rtl/core/uecb_ctrl.sv
rtl/core/uecb_datapath.sv
rtl/core/uncore_event_counter_bank_unit.sv
test/tb_uncore_event_counter_bank_unit.sv
